// File: rtl/core/lbh_pkg.sv
package lbh_pkg;

  localparam int LATTICE_DIM_DEF = 16;

  localparam int ROW_W      = 10;
  localparam int SMP_W      = 7;
  localparam int SPC_W      = 7;
  localparam int GRID_W     = 11;
  localparam int HGT_W      = 8;
  localparam int STAT_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  // Lattice indexes are carried at the width of the largest lattice supported.
  localparam int IDX_W = 6;
  // Divider working width for the coordinate split (spacing times lattice size).
  localparam int CRD_W = 13;
  // Weight of one sample: up to spacing squared.
  localparam int WT_W  = 14;
  // Weighted sum and denominator: up to one hundred times spacing squared.
  localparam int W_W   = 21;
  localparam int DEN_W = 21;
  localparam int P_W   = 31;
  localparam int REM_W = 30;
  localparam int Q_W   = 9;

  localparam logic [SMP_W-1:0] FULL_SCALE = 7'd100;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_WRITTEN = 2'd0,
    ST_VALID   = 2'd1,
    ST_RANGE   = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_SIZE  = 2'd0,
    REG_SPACING    = 2'd1,
    REG_MIN_HEIGHT = 2'd2,
    REG_MAX_HEIGHT = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [GRID_W-1:0]       grid_size;
    logic [SPC_W-1:0]        spacing;
    logic signed [HGT_W-1:0] min_height;
    logic signed [HGT_W-1:0] max_height;
    logic [DEN_W-1:0]        den;
  } cfg_t;

  typedef struct packed {
    status_t            st;
    logic [IDX_W-1:0]   r0;
    logic [IDX_W-1:0]   c0;
    logic [SPC_W-1:0]   fr;
    logic [SPC_W-1:0]   fc;
    logic [SMP_W-1:0]   smp;
  } coord_t;

  typedef struct packed {
    status_t        st;
    logic [W_W-1:0] w;
  } wsum_t;

  typedef struct packed {
    status_t               st;
    logic signed [P_W-1:0] p_span;
    logic signed [P_W-1:0] p_base;
  } scaled_t;

  // Two bits of restoring division: returns the new remainder and the quotient bits.
  function automatic logic [CRD_W+1:0] div_step2(input logic [CRD_W-1:0] rem,
                                                 input logic [CRD_W-1:0] dsh);
    logic [CRD_W-1:0] r;
    logic [1:0]       q;
    r = rem;
    q = 2'b00;
    if (r >= (dsh << 1)) begin
      r    = r - (dsh << 1);
      q[1] = 1'b1;
    end
    if (r >= dsh) begin
      r    = r - dsh;
      q[0] = 1'b1;
    end
    return {r, q};
  endfunction

endpackage

// File: rtl/core/lbh_if.sv
interface lbh_in_if import lbh_pkg::*;;
  logic             valid;
  logic             ready;
  logic             mode;
  logic [ROW_W-1:0] row;
  logic [ROW_W-1:0] col;
  logic [SMP_W-1:0] sample;

  modport source(output valid, mode, row, col, sample, input ready);
  modport sink(input valid, mode, row, col, sample, output ready);
endinterface

interface lbh_out_if import lbh_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [HGT_W-1:0] height;
  logic [STAT_W-1:0]       status;

  modport source(output valid, height, status, input ready);
  modport sink(input valid, height, status, output ready);
endinterface

// File: rtl/core/lbh_coord.sv
module lbh_coord import lbh_pkg::*; #(
  parameter int LATTICE_DIM = LATTICE_DIM_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_mode,
  input  logic [ROW_W-1:0] in_row,
  input  logic [ROW_W-1:0] in_col,
  input  logic [SMP_W-1:0] in_sample,
  output logic             out_valid,
  input  logic             out_ready,
  output coord_t           out_item
);

  localparam int QW   = (LATTICE_DIM > 1) ? $clog2(LATTICE_DIM) : 1;
  localparam int ITER = (QW + 1) / 2;
  localparam int QP   = 2 * ITER;
  localparam int CW   = $clog2(ITER + 1);

  logic             full_r;
  logic [CW-1:0]    cnt_r;
  status_t          st_r;
  logic [CRD_W-1:0] rrem_r, crem_r, dsh_r;
  logic [QP-1:0]    rq_r, cq_r;
  logic [SMP_W-1:0] smp_r;

  logic             accept, unload, busy;
  logic [CRD_W-1:0] lim;
  logic             rd_ok, wr_ok, edge_bad;
  logic [CRD_W+1:0] rstep, cstep;
  logic [SPC_W-1:0] fr, fc;
  logic [IDX_W-1:0] r0, c0;

  assign out_valid = full_r && (cnt_r == CW'(ITER));
  assign unload    = out_valid && out_ready;
  assign in_ready  = !full_r || unload;
  assign accept    = in_valid && in_ready;
  assign busy      = full_r && (cnt_r != CW'(ITER));

  always_comb begin
    lim   = CRD_W'(cfg.spacing) * CRD_W'(LATTICE_DIM);
    rd_ok = (cfg.spacing != '0) && (GRID_W'(in_row) < cfg.grid_size)
         && (GRID_W'(in_col) < cfg.grid_size)
         && (CRD_W'(in_row) < lim) && (CRD_W'(in_col) < lim);
    wr_ok = (in_row < ROW_W'(LATTICE_DIM)) && (in_col < ROW_W'(LATTICE_DIM));
    rstep = div_step2(rrem_r, dsh_r);
    cstep = div_step2(crem_r, dsh_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
      cnt_r  <= '0;
    end else if (accept) begin
      full_r <= 1'b1;
      cnt_r  <= (in_mode == MODE_READ && rd_ok) ? '0 : CW'(ITER);
    end else begin
      if (unload) begin
        full_r <= 1'b0;
      end
      if (busy) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      smp_r  <= (in_sample > FULL_SCALE) ? FULL_SCALE : in_sample;
      rrem_r <= CRD_W'(in_row);
      crem_r <= CRD_W'(in_col);
      dsh_r  <= CRD_W'(cfg.spacing) << (QP - 2);
      if (in_mode == MODE_WRITE) begin
        st_r <= wr_ok ? ST_WRITTEN : ST_RANGE;
        rq_r <= in_row[QP-1:0];
        cq_r <= in_col[QP-1:0];
      end else begin
        st_r <= rd_ok ? ST_VALID : ST_RANGE;
        rq_r <= '0;
        cq_r <= '0;
      end
    end else if (busy) begin
      rrem_r <= rstep[CRD_W+1:2];
      crem_r <= cstep[CRD_W+1:2];
      rq_r   <= {rq_r[QP-3:0], rstep[1:0]};
      cq_r   <= {cq_r[QP-3:0], cstep[1:0]};
      dsh_r  <= dsh_r >> 2;
    end
  end

  // A point between samples needs the next sample along that axis as well.
  always_comb begin
    fr       = rrem_r[SPC_W-1:0];
    fc       = crem_r[SPC_W-1:0];
    r0       = IDX_W'(rq_r);
    c0       = IDX_W'(cq_r);
    edge_bad = ((fr != '0) && (r0 == IDX_W'(LATTICE_DIM - 1)))
            || ((fc != '0) && (c0 == IDX_W'(LATTICE_DIM - 1)));
    out_item.st  = (st_r == ST_VALID && edge_bad) ? ST_RANGE : st_r;
    out_item.r0  = r0;
    out_item.c0  = c0;
    out_item.fr  = fr;
    out_item.fc  = fc;
    out_item.smp = smp_r;
  end

endmodule

// File: rtl/core/lbh_fetch.sv
module lbh_fetch import lbh_pkg::*; #(
  parameter int LATTICE_DIM = LATTICE_DIM_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  input  cfg_t   cfg,
  input  logic   in_valid,
  output logic   in_ready,
  input  coord_t in_item,
  output logic   out_valid,
  input  logic   out_ready,
  output wsum_t  out_item
);

  localparam int DEPTH = LATTICE_DIM * LATTICE_DIM;
  localparam int AW    = $clog2(DEPTH);

  logic [SMP_W-1:0] mem [DEPTH];
  logic [SMP_W-1:0] rd_r;

  logic             full_r, pend_r;
  logic [2:0]       issued_r;
  status_t          st_r;
  logic [IDX_W-1:0] r0_r, c0_r;
  logic [SPC_W-1:0] fr_r, fc_r;
  logic [WT_W-1:0]  weight_r;
  logic [W_W-1:0]   acc_r;

  logic             accept, unload, issue_more, do_read, do_write;
  logic [1:0]       k;
  logic [IDX_W-1:0] sr0, sc0, rsel, csel;
  logic [SPC_W-1:0] sfr, sfc, wr, wc;
  logic [WT_W-1:0]  weight;
  logic [AW-1:0]    addr;

  assign out_valid  = full_r && !pend_r;
  assign unload     = out_valid && out_ready;
  assign in_ready   = !full_r || unload;
  assign accept     = in_valid && in_ready;
  assign issue_more = full_r && (issued_r != 3'd4) && (st_r == ST_VALID);
  assign do_read    = (accept && in_item.st == ST_VALID) || issue_more;
  assign do_write   = accept && in_item.st == ST_WRITTEN;

  // The four corners are visited in the order near/near, near/far, far/near, far/far.
  always_comb begin
    if (accept) begin
      sr0 = in_item.r0;
      sc0 = in_item.c0;
      sfr = in_item.fr;
      sfc = in_item.fc;
      k   = 2'd0;
    end else begin
      sr0 = r0_r;
      sc0 = c0_r;
      sfr = fr_r;
      sfc = fc_r;
      k   = issued_r[1:0];
    end
    rsel   = sr0 + IDX_W'(k[1] && (sfr != '0));
    csel   = sc0 + IDX_W'(k[0] && (sfc != '0));
    wr     = k[1] ? sfr : (cfg.spacing - sfr);
    wc     = k[0] ? sfc : (cfg.spacing - sfc);
    weight = WT_W'(wr) * WT_W'(wc);
    addr   = AW'(int'(rsel) * LATTICE_DIM + int'(csel));
  end

  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[addr] <= in_item.smp;
    end else if (do_read) begin
      rd_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r   <= 1'b0;
      pend_r   <= 1'b0;
      issued_r <= '0;
    end else if (accept) begin
      full_r   <= 1'b1;
      pend_r   <= (in_item.st == ST_VALID);
      issued_r <= (in_item.st == ST_VALID) ? 3'd1 : 3'd4;
    end else begin
      if (unload) begin
        full_r <= 1'b0;
      end
      if (full_r) begin
        pend_r <= issue_more;
        if (issue_more) begin
          issued_r <= issued_r + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      st_r  <= in_item.st;
      r0_r  <= in_item.r0;
      c0_r  <= in_item.c0;
      fr_r  <= in_item.fr;
      fc_r  <= in_item.fc;
      acc_r <= '0;
    end else if (full_r && pend_r) begin
      acc_r <= acc_r + W_W'(rd_r) * W_W'(weight_r);
    end
    if (do_read) begin
      weight_r <= weight;
    end
  end

  assign out_item.st = st_r;
  assign out_item.w  = acc_r;

endmodule

// File: rtl/core/lbh_scale.sv
module lbh_scale import lbh_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg,
  input  logic    in_valid,
  output logic    in_ready,
  input  wsum_t   in_item,
  output logic    out_valid,
  input  logic    out_ready,
  output scaled_t out_item
);

  logic    full_r;
  scaled_t item_r;
  logic    accept;
  logic signed [HGT_W:0] span;

  assign in_ready  = !full_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = full_r;
  assign out_item  = item_r;
  assign span      = (HGT_W+1)'(cfg.max_height) - (HGT_W+1)'(cfg.min_height);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
    end else if (accept) begin
      full_r <= 1'b1;
    end else if (out_ready) begin
      full_r <= 1'b0;
    end
  end

  // Height numerator is span * w + min * den; the two products are formed side by side.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.st     <= in_item.st;
      item_r.p_span <= P_W'(span) * P_W'($signed({1'b0, in_item.w}));
      item_r.p_base <= P_W'(cfg.min_height) * P_W'($signed({1'b0, cfg.den}));
    end
  end

endmodule

// File: rtl/core/lbh_quot.sv
module lbh_quot import lbh_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cfg_t                    cfg,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  scaled_t                 in_item,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [HGT_W-1:0] out_height,
  output logic [STAT_W-1:0]       out_status
);

  localparam logic [1:0] ITER = 2'd3;

  logic             full_r, neg_r;
  logic [1:0]       cnt_r;
  status_t          st_r;
  logic [REM_W-1:0] rem_r, dsh_r;
  logic [Q_W-1:0]   q_r;

  logic             accept, unload, busy;
  logic signed [31:0] num;
  logic [31:0]      mag;
  logic [REM_W-1:0] rem_n, trial;
  logic [2:0]       qbits;
  logic [Q_W-1:0]   q_signed;

  assign out_valid = full_r && (cnt_r == ITER);
  assign unload    = out_valid && out_ready;
  assign in_ready  = !full_r || unload;
  assign accept    = in_valid && in_ready;
  assign busy      = full_r && (cnt_r != ITER);

  always_comb begin
    num   = 32'(in_item.p_span) + 32'(in_item.p_base);
    mag   = num[31] ? 32'(-num) : 32'(num);
    rem_n = rem_r;
    qbits = '0;
    for (int j = 0; j < 3; j++) begin
      trial = dsh_r << (2 - j);
      if (rem_n >= trial) begin
        rem_n        = rem_n - trial;
        qbits[2 - j] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
      cnt_r  <= '0;
    end else if (accept) begin
      full_r <= 1'b1;
      cnt_r  <= (in_item.st == ST_VALID) ? 2'd0 : ITER;
    end else begin
      if (unload) begin
        full_r <= 1'b0;
      end
      if (busy) begin
        cnt_r <= cnt_r + 2'd1;
      end
    end
  end

  // Three quotient bits a cycle, most significant first; the quotient never exceeds 128.
  always_ff @(posedge clk) begin
    if (accept) begin
      st_r  <= in_item.st;
      neg_r <= num[31];
      rem_r <= REM_W'(mag);
      dsh_r <= REM_W'(cfg.den) << 6;
      q_r   <= '0;
    end else if (busy) begin
      rem_r <= rem_n;
      dsh_r <= dsh_r >> 3;
      q_r   <= {q_r[Q_W-4:0], qbits};
    end
  end

  assign q_signed   = neg_r ? (~q_r + 1'b1) : q_r;
  assign out_height = (st_r == ST_VALID) ? HGT_W'(q_signed) : '0;
  assign out_status = st_r;

endmodule

// File: rtl/core/lattice_bilinear_heightmap.sv
// Channel   Direction  Beat contents
// in_ch     sink       mode, row, col, sample
// out_ch    source     height, status
// cfg_*     write      cfg_idx selects register, cfg_wdata carries the value
//
// One result beat per input beat, in order. A sample write or an item that
// fails the input range check skips the corner reads and the divider steps, so
// such beats flow at one per cycle while the sink does not stall. A height read
// holds the single-port lattice memory for four corner reads and the final
// accumulate, which sets the read rate. Reset is synchronous and empties the
// pipeline; lattice contents are not cleared.
// Each stage holds one beat and takes the next in the cycle its result leaves.
module lattice_bilinear_heightmap import lbh_pkg::*; #(
  parameter int LATTICE_DIM = LATTICE_DIM_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  lbh_in_if.sink                in_ch,
  lbh_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [GRID_W-1:0]       grid_size_r;
  logic [SPC_W-1:0]        spacing_r;
  logic signed [HGT_W-1:0] min_height_r, max_height_r;
  logic [WT_W-1:0]         sq_r;
  logic [DEN_W-1:0]        den_r;
  cfg_t                    cfg;

  logic   c_valid, c_ready, f_valid, f_ready, s_valid, s_ready;
  coord_t c_item;
  wsum_t  f_item;
  scaled_t s_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_size_r  <= 11'd101;
      spacing_r    <= 7'd20;
      min_height_r <= -8'sd5;
      max_height_r <= 8'sd15;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_idx))
        REG_GRID_SIZE:  grid_size_r  <= cfg_wdata;
        REG_SPACING:    spacing_r    <= cfg_wdata[SPC_W-1:0];
        REG_MIN_HEIGHT: min_height_r <= cfg_wdata[HGT_W-1:0];
        REG_MAX_HEIGHT: max_height_r <= cfg_wdata[HGT_W-1:0];
        default: ;
      endcase
    end
  end

  // The denominator settles through sq_r and then den_r after a spacing write, well before any read needs it.
  always_ff @(posedge clk) begin
    sq_r  <= WT_W'(spacing_r) * WT_W'(spacing_r);
    den_r <= DEN_W'(sq_r) * DEN_W'(FULL_SCALE);
  end

  always_comb begin
    cfg.grid_size  = grid_size_r;
    cfg.spacing    = spacing_r;
    cfg.min_height = min_height_r;
    cfg.max_height = max_height_r;
    cfg.den        = den_r;
  end

  lbh_coord #(.LATTICE_DIM(LATTICE_DIM)) u_coord (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_mode   (in_ch.mode),
    .in_row    (in_ch.row),
    .in_col    (in_ch.col),
    .in_sample (in_ch.sample),
    .out_valid (c_valid),
    .out_ready (c_ready),
    .out_item  (c_item)
  );

  lbh_fetch #(.LATTICE_DIM(LATTICE_DIM)) u_fetch (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (c_valid),
    .in_ready  (c_ready),
    .in_item   (c_item),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_item  (f_item)
  );

  lbh_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_item   (f_item),
    .out_valid (s_valid),
    .out_ready (s_ready),
    .out_item  (s_item)
  );

  lbh_quot u_quot (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_valid   (s_valid),
    .in_ready   (s_ready),
    .in_item    (s_item),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_height (out_ch.height),
    .out_status (out_ch.status)
  );

endmodule

// File: rtl/core/lbh_checker.sv
module lbh_checker import lbh_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [HGT_W-1:0] out_height,
  input logic [STAT_W-1:0]       out_status
);

  // A held result beat must not change while the sink stalls.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_height) && $stable(out_status))
    else $error("result beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

  a_zero_height: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_VALID |-> out_height == '0)
    else $error("non-zero height on a beat without a valid height");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == ST_WRITTEN || out_status == ST_VALID
                  || out_status == ST_RANGE)
    else $error("undefined status code");

endmodule

bind lattice_bilinear_heightmap lbh_checker u_lbh_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_height (out_ch.height),
  .out_status (out_ch.status)
);
